// ----- hw/rtl/ptcr_pkg.sv -----
// shared types, constants and scale tables of the pwm trace column raster
package ptcr_pkg;

    localparam int PLOT_WIDTH_DEF  = 300;
    localparam int PLOT_HEIGHT_DEF = 160;
    localparam int PLOT_X0         = 10;
    localparam int PLOT_Y0         = 40;

    localparam int COL_W      = 9;
    localparam int PH_W       = COL_W + 1;
    localparam int PH_MAX     = 1 << COL_W;
    localparam int DIV_W      = 13;
    localparam int RCP_W      = 26;
    localparam int RCP_SHIFT  = 32;
    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int SCALE_LAT  = 5;
    localparam int FRONT_DLY  = SCALE_LAT + 1;
    localparam int DIV_STG    = 3;
    localparam int QUEUE_DEPTH = 16;

    localparam logic [1:0] VS_1000 = 2'd0;
    localparam logic [1:0] VS_3300 = 2'd1;
    localparam logic [1:0] TS_100  = 2'd0;
    localparam logic [1:0] TS_500  = 2'd1;
    localparam logic [1:0] TS_1000 = 2'd2;
    localparam logic [1:0] TS_5000 = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOLT_SCALE,
        CFG_TIME_SCALE,
        CFG_HIGH_LEVEL_MV,
        CFG_LOW_LEVEL_MV,
        CFG_PERIOD_TIME_US,
        CFG_HIGH_TIME_US,
        CFG_TRACE_COLOR,
        CFG_BASELINE_COLOR
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CLS_BLANK,
        CLS_HIGH,
        CLS_LOW,
        CLS_EDGE
    } t_cls;

    typedef struct packed {
        logic            trace_on;
        logic [PH_W-1:0] per;
        logic [PH_W-1:0] hpx;
    } t_timing;

    typedef struct packed {
        logic [COL_W-1:0] col;
        t_cls             cls;
    } t_entry;

    // divisors and floor(2^32 / divisor) for the time and volt scales
    function automatic logic [DIV_W-1:0] us_div(input logic [1:0] code);
        unique case (code)
            TS_100:  return DIV_W'(100);
            TS_500:  return DIV_W'(500);
            TS_1000: return DIV_W'(1000);
            TS_5000: return DIV_W'(5000);
        endcase
    endfunction

    function automatic logic [RCP_W-1:0] us_rcp(input logic [1:0] code);
        unique case (code)
            TS_100:  return RCP_W'(42949672);
            TS_500:  return RCP_W'(8589934);
            TS_1000: return RCP_W'(4294967);
            TS_5000: return RCP_W'(858993);
        endcase
    endfunction

    // unused code 3 behaves as 5000 mV
    function automatic logic [DIV_W-1:0] mv_div(input logic [1:0] code);
        unique case (code)
            VS_1000: return DIV_W'(1000);
            VS_3300: return DIV_W'(3300);
            default: return DIV_W'(5000);
        endcase
    endfunction

    function automatic logic [RCP_W-1:0] mv_rcp(input logic [1:0] code);
        unique case (code)
            VS_1000: return RCP_W'(4294967);
            VS_3300: return RCP_W'(1301505);
            default: return RCP_W'(858993);
        endcase
    endfunction

endpackage

// ----- hw/rtl/ptcr_scale.sv -----
// configuration registers and the scaling pipeline for period, high time and levels
module ptcr_scale #(
    parameter int PLOT_WIDTH  = ptcr_pkg::PLOT_WIDTH_DEF,
    parameter int PLOT_HEIGHT = ptcr_pkg::PLOT_HEIGHT_DEF,
    parameter int ROW_W       = $clog2(ptcr_pkg::PLOT_Y0 + PLOT_HEIGHT)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ptcr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ptcr_pkg::CFG_W-1:0]        i_cfg_wdata,
    output ptcr_pkg::t_timing                 o_timing,
    output logic [ROW_W-1:0]                  o_high_row,
    output logic [ROW_W-1:0]                  o_low_row,
    output logic [15:0]                       o_trace_color,
    output logic [15:0]                       o_baseline_color
);

    localparam int HPX      = PLOT_WIDTH / 10;
    localparam int VPX      = PLOT_HEIGHT / 8;
    localparam int TXW      = 24 + $clog2(HPX + 1);
    localparam int VXW      = 16 + $clog2(VPX + 1);
    localparam int PTW      = TXW + ptcr_pkg::RCP_W;
    localparam int PVW      = VXW + ptcr_pkg::RCP_W;
    localparam int HALF     = PLOT_HEIGHT / 2;
    localparam int ZERO_ROW = ptcr_pkg::PLOT_Y0 + HALF;
    localparam int DW       = ptcr_pkg::DIV_W;
    localparam int RW       = ptcr_pkg::RCP_W;

    logic [1:0]  r_volt_scale;
    logic [1:0]  r_time_scale;
    logic [15:0] r_high_mv;
    logic [15:0] r_low_mv;
    logic [23:0] r_period_us;
    logic [23:0] r_high_us;
    logic [15:0] r_trace_color;
    logic [15:0] r_baseline_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volt_scale     <= '0;
            r_time_scale     <= '0;
            r_high_mv        <= '0;
            r_low_mv         <= '0;
            r_period_us      <= '0;
            r_high_us        <= '0;
            r_trace_color    <= '0;
            r_baseline_color <= '0;
        end else if (i_cfg_we) begin
            unique case (ptcr_pkg::t_cfg_idx'(i_cfg_index))
                ptcr_pkg::CFG_VOLT_SCALE:     r_volt_scale     <= i_cfg_wdata[1:0];
                ptcr_pkg::CFG_TIME_SCALE:     r_time_scale     <= i_cfg_wdata[1:0];
                ptcr_pkg::CFG_HIGH_LEVEL_MV:  r_high_mv        <= i_cfg_wdata[15:0];
                ptcr_pkg::CFG_LOW_LEVEL_MV:   r_low_mv         <= i_cfg_wdata[15:0];
                ptcr_pkg::CFG_PERIOD_TIME_US: r_period_us      <= i_cfg_wdata[23:0];
                ptcr_pkg::CFG_HIGH_TIME_US:   r_high_us        <= i_cfg_wdata[23:0];
                ptcr_pkg::CFG_TRACE_COLOR:    r_trace_color    <= i_cfg_wdata[15:0];
                ptcr_pkg::CFG_BASELINE_COLOR: r_baseline_color <= i_cfg_wdata[15:0];
            endcase
        end
    end

    assign o_trace_color    = r_trace_color;
    assign o_baseline_color = r_baseline_color;

    // index 0 is the period, 1 the high time; volt index 0 is high level, 1 low level
    logic [23:0]    hus;
    logic [TXW-1:0] r1_tx [2];
    logic [VXW-1:0] r1_vx [2];
    logic [DW-1:0]  r1_tdiv, r1_vdiv;
    logic [RW-1:0]  r1_trcp, r1_vrcp;
    logic           r1_on, r1_hus_nz;

    assign hus = (r_high_us > r_period_us) ? r_period_us : r_high_us;

    always_ff @(posedge i_clk) begin
        r1_tx[0]  <= TXW'(r_period_us) * TXW'(HPX);
        r1_tx[1]  <= TXW'(hus) * TXW'(HPX);
        r1_vx[0]  <= VXW'(r_high_mv) * VXW'(VPX);
        r1_vx[1]  <= VXW'(r_low_mv) * VXW'(VPX);
        r1_tdiv   <= ptcr_pkg::us_div(r_time_scale);
        r1_trcp   <= ptcr_pkg::us_rcp(r_time_scale);
        r1_vdiv   <= ptcr_pkg::mv_div(r_volt_scale);
        r1_vrcp   <= ptcr_pkg::mv_rcp(r_volt_scale);
        r1_on     <= (r_period_us != '0);
        r1_hus_nz <= (hus != '0);
    end

    // estimate quotient by reciprocal, one short of exact at most
    logic [PTW-1:0] t_prod [2];
    logic [PVW-1:0] v_prod [2];
    logic [TXW-1:0] r2_tx [2], r2_tq0 [2];
    logic [VXW-1:0] r2_vx [2], r2_vq0 [2];
    logic [DW-1:0]  r2_tdiv, r2_vdiv;
    logic           r2_on, r2_hus_nz;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            t_prod[i] = PTW'(r1_tx[i]) * PTW'(r1_trcp);
            v_prod[i] = PVW'(r1_vx[i]) * PVW'(r1_vrcp);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 2; i++) begin
            r2_tq0[i] <= TXW'(t_prod[i][PTW-1:ptcr_pkg::RCP_SHIFT]);
            r2_vq0[i] <= VXW'(v_prod[i][PVW-1:ptcr_pkg::RCP_SHIFT]);
        end
        r2_tx     <= r1_tx;
        r2_vx     <= r1_vx;
        r2_tdiv   <= r1_tdiv;
        r2_vdiv   <= r1_vdiv;
        r2_on     <= r1_on;
        r2_hus_nz <= r1_hus_nz;
    end

    // back-multiply the estimate
    logic [TXW-1:0] r3_tx [2], r3_tq0 [2], r3_tp [2];
    logic [VXW-1:0] r3_vx [2], r3_vq0 [2], r3_vp [2];
    logic [DW-1:0]  r3_tdiv, r3_vdiv;
    logic           r3_on, r3_hus_nz;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 2; i++) begin
            r3_tp[i] <= r2_tq0[i] * TXW'(r2_tdiv);
            r3_vp[i] <= r2_vq0[i] * VXW'(r2_vdiv);
        end
        r3_tx     <= r2_tx;
        r3_vx     <= r2_vx;
        r3_tq0    <= r2_tq0;
        r3_vq0    <= r2_vq0;
        r3_tdiv   <= r2_tdiv;
        r3_vdiv   <= r2_vdiv;
        r3_on     <= r2_on;
        r3_hus_nz <= r2_hus_nz;
    end

    // correct by one where the remainder reaches the divisor
    logic [TXW-1:0] r4_tq [2];
    logic [VXW-1:0] r4_vq [2];
    logic           r4_on, r4_hus_nz;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 2; i++) begin
            r4_tq[i] <= r3_tq0[i] +
                        (((r3_tx[i] - r3_tp[i]) >= TXW'(r3_tdiv)) ? TXW'(1) : '0);
            r4_vq[i] <= r3_vq0[i] +
                        (((r3_vx[i] - r3_vp[i]) >= VXW'(r3_vdiv)) ? VXW'(1) : '0);
        end
        r4_on     <= r3_on;
        r4_hus_nz <= r3_hus_nz;
    end

    // minimums, clamps to the column range and level rows
    logic [TXW-1:0]   per1, hq;
    logic [ROW_W-1:0] n_row [2];

    always_comb begin
        per1 = (r4_tq[0] == '0) ? TXW'(1) : r4_tq[0];
        hq   = r4_tq[1];
        if (hq == '0 && r4_hus_nz) begin
            hq = TXW'(1);
        end
        if (hq > per1) begin
            hq = per1;
        end
        for (int i = 0; i < 2; i++) begin
            n_row[i] = (r4_vq[i] > VXW'(HALF)) ? ROW_W'(ptcr_pkg::PLOT_Y0)
                                               : ROW_W'(ZERO_ROW) - ROW_W'(r4_vq[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        o_timing.trace_on <= r4_on;
        o_timing.per <= (per1 > TXW'(ptcr_pkg::PH_MAX)) ? ptcr_pkg::PH_W'(ptcr_pkg::PH_MAX)
                                                         : ptcr_pkg::PH_W'(per1);
        o_timing.hpx <= (hq > TXW'(ptcr_pkg::PH_MAX)) ? ptcr_pkg::PH_W'(ptcr_pkg::PH_MAX)
                                                       : ptcr_pkg::PH_W'(hq);
        o_high_row <= n_row[0];
        o_low_row  <= n_row[1];
    end

endmodule

// ----- hw/rtl/ptcr_front.sv -----
// front end: column intake, phase by pipelined remainder, classification, credit count
module ptcr_front #(
    parameter int PLOT_WIDTH = ptcr_pkg::PLOT_WIDTH_DEF,
    parameter int DEPTH      = ptcr_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [ptcr_pkg::COL_W-1:0]    i_column,
    output logic                          o_full,
    input  ptcr_pkg::t_timing             i_timing,
    input  logic                          i_deq,
    output logic                          o_wr,
    output ptcr_pkg::t_entry              o_entry
);

    localparam int DLY    = ptcr_pkg::FRONT_DLY;
    localparam int NSTG   = ptcr_pkg::DIV_STG;
    localparam int CW     = ptcr_pkg::COL_W;
    localparam int PW     = ptcr_pkg::PH_W;
    localparam int BPS    = CW / NSTG;
    localparam int USED_W = $clog2(DEPTH + 1);

    logic              accept;
    logic [USED_W-1:0] r_used;

    assign accept = i_push && !o_full;
    assign o_full = (r_used == USED_W'(DEPTH));

    // items in the front and the queue hold a credit until the back takes them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= r_used + USED_W'(accept) - USED_W'(i_deq);
        end
    end

    // hold columns until the scaled timing has settled after a register write
    logic          r_dly_vld [DLY];
    logic [CW-1:0] r_dly_col [DLY];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DLY; i++) begin
                r_dly_vld[i] <= 1'b0;
            end
        end else begin
            r_dly_vld[0] <= accept;
            for (int i = 1; i < DLY; i++) begin
                r_dly_vld[i] <= r_dly_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dly_col[0] <= i_column;
        for (int i = 1; i < DLY; i++) begin
            r_dly_col[i] <= r_dly_col[i-1];
        end
    end

    // restoring remainder, three bits of the column per stage
    logic          in_vld [NSTG];
    logic [CW-1:0] in_col [NSTG];
    logic [PW-1:0] in_rem [NSTG];
    logic [PW-1:0] n_rem  [NSTG];
    logic          r_div_vld [NSTG];
    logic [CW-1:0] r_div_col [NSTG];
    logic [PW-1:0] r_div_rem [NSTG];

    always_comb begin
        in_vld[0] = r_dly_vld[DLY-1];
        in_col[0] = r_dly_col[DLY-1];
        in_rem[0] = '0;
        for (int s = 1; s < NSTG; s++) begin
            in_vld[s] = r_div_vld[s-1];
            in_col[s] = r_div_col[s-1];
            in_rem[s] = r_div_rem[s-1];
        end
        for (int s = 0; s < NSTG; s++) begin
            n_rem[s] = in_rem[s];
            for (int b = 0; b < BPS; b++) begin
                n_rem[s] = {n_rem[s][PW-2:0], in_col[s][CW-1-s*BPS-b]};
                if (n_rem[s] >= i_timing.per) begin
                    n_rem[s] = n_rem[s] - i_timing.per;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NSTG; s++) begin
                r_div_vld[s] <= 1'b0;
            end
        end else begin
            for (int s = 0; s < NSTG; s++) begin
                r_div_vld[s] <= in_vld[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NSTG; s++) begin
            r_div_col[s] <= in_col[s];
            r_div_rem[s] <= n_rem[s];
        end
    end

    logic [CW-1:0] col;
    logic [PW-1:0] phase;
    logic          in_plot;
    logic          is_edge;

    assign col     = r_div_col[NSTG-1];
    assign phase   = r_div_rem[NSTG-1];
    assign in_plot = (int'(col) < PLOT_WIDTH);
    assign is_edge = (phase == i_timing.hpx) || (phase == '0 && col != '0);

    always_comb begin
        o_entry.col = col;
        if (!i_timing.trace_on || !in_plot) begin
            o_entry.cls = ptcr_pkg::CLS_BLANK;
        end else if (is_edge) begin
            o_entry.cls = ptcr_pkg::CLS_EDGE;
        end else if (phase < i_timing.hpx) begin
            o_entry.cls = ptcr_pkg::CLS_HIGH;
        end else begin
            o_entry.cls = ptcr_pkg::CLS_LOW;
        end
    end

    assign o_wr = r_div_vld[NSTG-1];

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(DEPTH))
        else $error("credit count above queue depth");

    a_wr_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr |-> r_used != '0)
        else $error("column leaving front without a credit");

    a_deq_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_deq |-> r_used != '0)
        else $error("queue read with no credit outstanding");

endmodule

// ----- hw/rtl/ptcr_queue.sv -----
// small show-ahead queue between front and back
module ptcr_queue #(
    parameter int WIDTH = $bits(ptcr_pkg::t_entry),
    parameter int DEPTH = ptcr_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            r_count <= r_count + CNT_W'(i_wr) - CNT_W'(i_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr && !i_rd |-> r_count != CNT_W'(DEPTH))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> r_count != '0)
        else $error("queue underflow");

endmodule

// ----- hw/rtl/ptcr_back.sv -----
// back end: rows and visibility of a classified column into the result register
module ptcr_back #(
    parameter int PLOT_HEIGHT = ptcr_pkg::PLOT_HEIGHT_DEF,
    parameter int ROW_W       = $clog2(ptcr_pkg::PLOT_Y0 + PLOT_HEIGHT)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  ptcr_pkg::t_entry            i_entry,
    output logic                        o_deq,
    input  logic [ROW_W-1:0]            i_high_row,
    input  logic [ROW_W-1:0]            i_low_row,
    input  logic [15:0]                 i_trace_color,
    input  logic [15:0]                 i_baseline_color,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [8:0]                  o_screen_x,
    output logic [7:0]                  o_trace_top,
    output logic [7:0]                  o_trace_bottom,
    output logic                        o_trace_shown,
    output logic [7:0]                  o_baseline_row,
    output logic                        o_baseline_shown,
    output logic [15:0]                 o_pixel_trace_color,
    output logic [15:0]                 o_pixel_baseline_color
);

    localparam int ZERO_ROW = ptcr_pkg::PLOT_Y0 + PLOT_HEIGHT / 2;

    logic                        r_vld;
    logic [ptcr_pkg::COL_W-1:0]  r_col;
    logic [ROW_W-1:0]            r_top, r_bot;
    logic                        r_shown, r_base;
    logic [15:0]                 r_tcolor, r_bcolor;

    logic             take;
    logic [ROW_W-1:0] row_min, row_max;
    logic [ROW_W-1:0] n_top, n_bot;
    logic             n_shown, n_base;

    assign take  = !i_q_empty && (!r_vld || i_pop);
    assign o_deq = take;

    assign row_min = (i_high_row < i_low_row) ? i_high_row : i_low_row;
    assign row_max = (i_high_row < i_low_row) ? i_low_row : i_high_row;

    always_comb begin
        n_shown = 1'b1;
        unique case (i_entry.cls)
            ptcr_pkg::CLS_BLANK: begin
                n_top   = '0;
                n_bot   = '0;
                n_shown = 1'b0;
            end
            ptcr_pkg::CLS_HIGH: begin
                n_top = i_high_row;
                n_bot = i_high_row;
            end
            ptcr_pkg::CLS_LOW: begin
                n_top = i_low_row;
                n_bot = i_low_row;
            end
            ptcr_pkg::CLS_EDGE: begin
                n_top = row_min;
                n_bot = row_max;
            end
        endcase
        // zero line hidden where the trace run covers it, and in blank columns
        n_base = n_shown && !(ROW_W'(ZERO_ROW) >= n_top && ROW_W'(ZERO_ROW) <= n_bot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (take) begin
            r_vld <= 1'b1;
        end else if (i_pop) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_col    <= i_entry.col;
            r_top    <= n_top;
            r_bot    <= n_bot;
            r_shown  <= n_shown;
            r_base   <= n_base;
            r_tcolor <= i_trace_color;
            r_bcolor <= i_baseline_color;
        end
    end

    assign o_empty                = !r_vld;
    assign o_screen_x             = r_col + 9'(ptcr_pkg::PLOT_X0);
    assign o_trace_top            = 8'(r_top);
    assign o_trace_bottom         = 8'(r_bot);
    assign o_trace_shown          = r_shown;
    assign o_baseline_row         = 8'(ZERO_ROW);
    assign o_baseline_shown       = r_base;
    assign o_pixel_trace_color    = r_tcolor;
    assign o_pixel_baseline_color = r_bcolor;

    a_run_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && r_shown |-> r_top <= r_bot)
        else $error("trace run top below bottom");

    a_blank_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !r_shown |-> !r_base && r_top == '0 && r_bot == '0)
        else $error("blank column carries trace or zero line");

    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_vld)
        else $error("result register empty after a take");

endmodule

// ----- hw/rtl/pwm_trace_column_raster.sv -----
// top level of the pwm trace column raster
//
// Draws an ideal PWM waveform into an oscilloscope plot one screen column at
// a time. Columns go in through a queue-like port: push with the column index,
// held off while full is high. Results come out the same way: while empty is
// low the oldest result sits on the o_ ports and pop takes it. Each column
// gives exactly one result: its screen x, the first and last trace row, whether
// the trace and the zero line show, and the two pixel colors.
// Registers are written through i_cfg_we / i_cfg_index / i_cfg_wdata; the user
// must write them only while no column is in flight, as the block does not
// enforce it; a column may follow the cycle after a write. On its way to the
// output ports a column passes a hold line while the register scaling pipeline
// settles, three remainder stages for column mod period, one queue write and
// one result register. Sustained rate is one column per clock while full is
// low; a sixteen-entry credit count covers all columns in the front and the
// queue, so full rises only when the receiver has stalled long enough to fill
// them. A stalled receiver keeps its result stable while the front keeps
// working until credits run out. Reset clears all configuration registers to
// zero, empties the pipeline and the queue, and clears full synchronously.
module pwm_trace_column_raster #(
    parameter int PLOT_WIDTH  = ptcr_pkg::PLOT_WIDTH_DEF,
    parameter int PLOT_HEIGHT = ptcr_pkg::PLOT_HEIGHT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ptcr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ptcr_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                              push,
    output logic                              full,
    input  logic [ptcr_pkg::COL_W-1:0]        i_column,
    output logic                              empty,
    input  logic                              pop,
    output logic [8:0]                        o_screen_x,
    output logic [7:0]                        o_trace_top,
    output logic [7:0]                        o_trace_bottom,
    output logic                              o_trace_shown,
    output logic [7:0]                        o_baseline_row,
    output logic                              o_baseline_shown,
    output logic [15:0]                       o_pixel_trace_color,
    output logic [15:0]                       o_pixel_baseline_color
);

    localparam int ROW_W = $clog2(ptcr_pkg::PLOT_Y0 + PLOT_HEIGHT);
    localparam int EW    = $bits(ptcr_pkg::t_entry);

    ptcr_pkg::t_timing timing;
    logic [ROW_W-1:0]  high_row, low_row;
    logic [15:0]       trace_color, baseline_color;
    logic              q_wr, q_rd, q_empty;
    ptcr_pkg::t_entry  wr_entry, rd_entry;
    logic [EW-1:0]     q_rdata;

    ptcr_scale #(
        .PLOT_WIDTH  (PLOT_WIDTH),
        .PLOT_HEIGHT (PLOT_HEIGHT),
        .ROW_W       (ROW_W)
    ) u_scale (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_timing         (timing),
        .o_high_row       (high_row),
        .o_low_row        (low_row),
        .o_trace_color    (trace_color),
        .o_baseline_color (baseline_color)
    );

    ptcr_front #(
        .PLOT_WIDTH (PLOT_WIDTH),
        .DEPTH      (ptcr_pkg::QUEUE_DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_column (i_column),
        .o_full   (full),
        .i_timing (timing),
        .i_deq    (q_rd),
        .o_wr     (q_wr),
        .o_entry  (wr_entry)
    );

    ptcr_queue #(
        .WIDTH (EW),
        .DEPTH (ptcr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (EW'(wr_entry)),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    assign rd_entry = ptcr_pkg::t_entry'(q_rdata);

    ptcr_back #(
        .PLOT_HEIGHT (PLOT_HEIGHT),
        .ROW_W       (ROW_W)
    ) u_back (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_q_empty              (q_empty),
        .i_entry                (rd_entry),
        .o_deq                  (q_rd),
        .i_high_row             (high_row),
        .i_low_row              (low_row),
        .i_trace_color          (trace_color),
        .i_baseline_color       (baseline_color),
        .i_pop                  (pop),
        .o_empty                (empty),
        .o_screen_x             (o_screen_x),
        .o_trace_top            (o_trace_top),
        .o_trace_bottom         (o_trace_bottom),
        .o_trace_shown          (o_trace_shown),
        .o_baseline_row         (o_baseline_row),
        .o_baseline_shown       (o_baseline_shown),
        .o_pixel_trace_color    (o_pixel_trace_color),
        .o_pixel_baseline_color (o_pixel_baseline_color)
    );

endmodule

// ----- bench/ptcr_checker.sv -----
// column predictor and result checker for the pwm trace column raster
`timescale 1ns / 1ps

module ptcr_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ptcr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ptcr_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                           i_push,
    input  logic                           i_full,
    input  logic [ptcr_pkg::COL_W-1:0]     i_column,
    input  logic                           i_empty,
    input  logic                           i_pop,
    input  logic [8:0]                     i_screen_x,
    input  logic [7:0]                     i_trace_top,
    input  logic [7:0]                     i_trace_bottom,
    input  logic                           i_trace_shown,
    input  logic [7:0]                     i_baseline_row,
    input  logic                           i_baseline_shown,
    input  logic [15:0]                    i_pixel_trace_color,
    input  logic [15:0]                    i_pixel_baseline_color,
    output int                             o_fail_count,
    output int                             o_outstanding,
    output int                             o_results_checked
);

    localparam int PLOT_W   = ptcr_pkg::PLOT_WIDTH_DEF;
    localparam int PLOT_H   = ptcr_pkg::PLOT_HEIGHT_DEF;
    localparam int ZERO_ROW = ptcr_pkg::PLOT_Y0 + PLOT_H / 2;
    localparam int ROW_MAX  = ptcr_pkg::PLOT_Y0 + PLOT_H - 1;
    localparam int PX_PER_VDIV = PLOT_H / 8;
    localparam int PX_PER_TDIV = PLOT_W / 10;

    typedef struct packed {
        logic [8:0]  screen_x;
        logic [7:0]  trace_top;
        logic [7:0]  trace_bottom;
        logic        trace_shown;
        logic [7:0]  baseline_row;
        logic        baseline_shown;
        logic [15:0] pixel_trace_color;
        logic [15:0] pixel_baseline_color;
    } column_result_t;

    // shadow of the block's registers
    logic [1:0]  volt_scale_q;
    logic [1:0]  time_scale_q;
    logic [15:0] high_mv_q;
    logic [15:0] low_mv_q;
    logic [23:0] period_time_q;
    logic [23:0] high_us_q;
    logic [15:0] trace_color_q;
    logic [15:0] baseline_color_q;

    column_result_t pending_columns[$];
    column_result_t oldest;
    int fail_count = 0;
    int results_checked = 0;

    assign o_fail_count      = fail_count;
    assign o_results_checked = results_checked;

    function automatic int unsigned mv_to_row(input logic [15:0] mv);
        longint row;
        longint mv_div;
        case (volt_scale_q)
            ptcr_pkg::VS_1000: mv_div = 1000;
            ptcr_pkg::VS_3300: mv_div = 3300;
            default:           mv_div = 5000;
        endcase
        row = ZERO_ROW - (longint'(mv) * PX_PER_VDIV) / mv_div;
        if (row < ptcr_pkg::PLOT_Y0) row = ptcr_pkg::PLOT_Y0;
        if (row > ROW_MAX) row = ROW_MAX;
        return int'(row);
    endfunction

    function automatic longint unsigned us_to_px(input logic [23:0] us);
        longint unsigned us_div;
        case (time_scale_q)
            ptcr_pkg::TS_100:  us_div = 100;
            ptcr_pkg::TS_500:  us_div = 500;
            ptcr_pkg::TS_1000: us_div = 1000;
            default:           us_div = 5000;
        endcase
        return (longint'(us) * PX_PER_TDIV) / us_div;
    endfunction

    function automatic column_result_t raster_column(
        input logic [ptcr_pkg::COL_W-1:0] col);
        column_result_t res;
        logic [23:0] clamped_high_us;
        longint unsigned per_px, high_px, phase;
        int unsigned high_row, low_row, top_row, bottom_row;
        res = '0;
        res.screen_x             = 9'(ptcr_pkg::PLOT_X0 + col);
        res.baseline_row         = 8'(ZERO_ROW);
        res.pixel_trace_color    = trace_color_q;
        res.pixel_baseline_color = baseline_color_q;
        if (period_time_q != 0 && col < PLOT_W) begin
            clamped_high_us = (high_us_q > period_time_q) ? period_time_q : high_us_q;
            high_row = mv_to_row(high_mv_q);
            low_row  = mv_to_row(low_mv_q);
            per_px   = us_to_px(period_time_q);
            high_px  = us_to_px(clamped_high_us);
            if (per_px == 0) per_px = 1;
            if (high_px == 0 && clamped_high_us != 0) high_px = 1;
            if (high_px > per_px) high_px = per_px;
            phase = col % per_px;
            // edge column spans both levels
            if (phase == high_px || (phase == 0 && col != 0)) begin
                top_row    = (high_row < low_row) ? high_row : low_row;
                bottom_row = (high_row < low_row) ? low_row : high_row;
            end else if (phase < high_px) begin
                top_row    = high_row;
                bottom_row = high_row;
            end else begin
                top_row    = low_row;
                bottom_row = low_row;
            end
            res.trace_top      = 8'(top_row);
            res.trace_bottom   = 8'(bottom_row);
            res.trace_shown    = 1'b1;
            res.baseline_shown = !(ZERO_ROW >= top_row && ZERO_ROW <= bottom_row);
        end
        return res;
    endfunction

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            volt_scale_q     <= '0;
            time_scale_q     <= '0;
            high_mv_q        <= '0;
            low_mv_q         <= '0;
            period_time_q    <= '0;
            high_us_q        <= '0;
            trace_color_q    <= '0;
            baseline_color_q <= '0;
            pending_columns.delete();
            o_outstanding    <= 0;
        end else begin
            if (i_cfg_we) begin
                case (ptcr_pkg::t_cfg_idx'(i_cfg_index))
                    ptcr_pkg::CFG_VOLT_SCALE:     volt_scale_q     <= i_cfg_wdata[1:0];
                    ptcr_pkg::CFG_TIME_SCALE:     time_scale_q     <= i_cfg_wdata[1:0];
                    ptcr_pkg::CFG_HIGH_LEVEL_MV:  high_mv_q        <= i_cfg_wdata[15:0];
                    ptcr_pkg::CFG_LOW_LEVEL_MV:   low_mv_q         <= i_cfg_wdata[15:0];
                    ptcr_pkg::CFG_PERIOD_TIME_US: period_time_q    <= i_cfg_wdata[23:0];
                    ptcr_pkg::CFG_HIGH_TIME_US:   high_us_q        <= i_cfg_wdata[23:0];
                    ptcr_pkg::CFG_TRACE_COLOR:    trace_color_q    <= i_cfg_wdata[15:0];
                    ptcr_pkg::CFG_BASELINE_COLOR: baseline_color_q <= i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            // result side first so a stray result never matches a column pushed now
            if (i_pop && !i_empty) begin
                if (pending_columns.size() == 0) begin
                    $error("result with no column waiting: screen_x %0d", i_screen_x);
                    fail_count++;
                end else begin
                    oldest = pending_columns.pop_front();
                    check_field("screen_x", oldest.screen_x, i_screen_x);
                    check_field("trace_top", oldest.trace_top, i_trace_top);
                    check_field("trace_bottom", oldest.trace_bottom, i_trace_bottom);
                    check_field("trace_shown", oldest.trace_shown, i_trace_shown);
                    check_field("baseline_row", oldest.baseline_row, i_baseline_row);
                    check_field("baseline_shown", oldest.baseline_shown,
                                i_baseline_shown);
                    check_field("pixel_trace_color", oldest.pixel_trace_color,
                                i_pixel_trace_color);
                    check_field("pixel_baseline_color", oldest.pixel_baseline_color,
                                i_pixel_baseline_color);
                    results_checked++;
                end
            end
            if (i_push && !i_full) begin
                pending_columns.push_back(raster_column(i_column));
            end
            o_outstanding <= pending_columns.size();
        end
    end

endmodule

// ----- bench/testbench.sv -----
// stimulus and verdict for the pwm trace column raster
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] VS_5000   = 2'd2;
    localparam logic [1:0] VS_UNUSED = 2'd3;
    localparam int RANDOM_COLUMNS = 1100;
    localparam int HOLD_CYCLES    = 80;
    localparam int QUIET_LIMIT    = 1000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int CW             = ptcr_pkg::CFG_W;
    localparam int COLW           = ptcr_pkg::COL_W;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [ptcr_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CW-1:0]                  i_cfg_wdata = '0;
    logic                           push = 1'b0;
    logic                           full;
    logic [COLW-1:0]                i_column = '0;
    logic                           empty;
    logic                           pop = 1'b0;
    logic [8:0]                     o_screen_x;
    logic [7:0]                     o_trace_top;
    logic [7:0]                     o_trace_bottom;
    logic                           o_trace_shown;
    logic [7:0]                     o_baseline_row;
    logic                           o_baseline_shown;
    logic [15:0]                    o_pixel_trace_color;
    logic [15:0]                    o_pixel_baseline_color;

    int fail_count;
    int outstanding;
    int results_checked;

    int quiet_cycles = 0;
    int full_stall_cycles = 0;
    int columns_sent = 0;
    int settings_applied = 0;
    int hold_requests = 0;
    int holds_served = 0;
    bit sender_burst = 1'b0;
    bit receiver_burst = 1'b0;

    always #10 i_clk = ~i_clk;

    pwm_trace_column_raster i_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_wdata            (i_cfg_wdata),
        .push                   (push),
        .full                   (full),
        .i_column               (i_column),
        .empty                  (empty),
        .pop                    (pop),
        .o_screen_x             (o_screen_x),
        .o_trace_top            (o_trace_top),
        .o_trace_bottom         (o_trace_bottom),
        .o_trace_shown          (o_trace_shown),
        .o_baseline_row         (o_baseline_row),
        .o_baseline_shown       (o_baseline_shown),
        .o_pixel_trace_color    (o_pixel_trace_color),
        .o_pixel_baseline_color (o_pixel_baseline_color)
    );

    ptcr_checker i_checker (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_wdata            (i_cfg_wdata),
        .i_push                 (push),
        .i_full                 (full),
        .i_column               (i_column),
        .i_empty                (empty),
        .i_pop                  (pop),
        .i_screen_x             (o_screen_x),
        .i_trace_top            (o_trace_top),
        .i_trace_bottom         (o_trace_bottom),
        .i_trace_shown          (o_trace_shown),
        .i_baseline_row         (o_baseline_row),
        .i_baseline_shown       (o_baseline_shown),
        .i_pixel_trace_color    (o_pixel_trace_color),
        .i_pixel_baseline_color (o_pixel_baseline_color),
        .o_fail_count           (fail_count),
        .o_outstanding          (outstanding),
        .o_results_checked      (results_checked)
    );

    // quiet-cycle watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (push && full) full_stall_cycles <= full_stall_cycles + 1;
            if ((push && !full) || (pop && !empty) || i_cfg_we) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // receiver: random stall per result, long hold-off on request
    initial begin
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_requests != holds_served) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds_served++;
            end
            if ($urandom_range(0, 31) == 0) receiver_burst = !receiver_burst;
            stall = receiver_burst ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
        end
    end

    task automatic write_reg(input ptcr_pkg::t_cfg_idx idx, input logic [CW-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [1:0] volt, input logic [1:0] tsc,
                                 input logic [15:0] high_mv, input logic [15:0] low_mv,
                                 input logic [23:0] span_us, input logic [23:0] high_us,
                                 input logic [15:0] tcolor, input logic [15:0] bcolor);
        write_reg(ptcr_pkg::CFG_VOLT_SCALE, CW'(volt));
        write_reg(ptcr_pkg::CFG_TIME_SCALE, CW'(tsc));
        write_reg(ptcr_pkg::CFG_HIGH_LEVEL_MV, CW'(high_mv));
        write_reg(ptcr_pkg::CFG_LOW_LEVEL_MV, CW'(low_mv));
        write_reg(ptcr_pkg::CFG_PERIOD_TIME_US, span_us);
        write_reg(ptcr_pkg::CFG_HIGH_TIME_US, high_us);
        write_reg(ptcr_pkg::CFG_TRACE_COLOR, CW'(tcolor));
        write_reg(ptcr_pkg::CFG_BASELINE_COLOR, CW'(bcolor));
        i_cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // called in step with the clock; returns once the column transfer has taken place
    task automatic send_column(input logic [COLW-1:0] col);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push     <= 1'b1;
        i_column <= col;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        columns_sent++;
    endtask

    // outstanding is registered, so look at it only after the next edge
    task automatic drain_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_millivolts();
        case ($urandom_range(0, 3))
            0:       return 16'd0;
            1:       return 16'($urandom_range(0, 16'hFFFF));
            2:       return 16'($urandom_range(0, 30000));
            default: return 16'($urandom_range(0, 4000));
        endcase
    endfunction

    initial begin
        int unsigned us_per_div_tab[4];
        int unsigned usdiv, span_us, high_us, high_cap, count, random_sent, phase_no;
        logic [1:0] volt, tsc;

        us_per_div_tab = '{100, 500, 1000, 5000};
        random_sent = 0;
        phase_no = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers at reset: zero period blanks every column
        send_column(9'd0);
        send_column(9'd299);
        send_column(9'd511);
        drain_results();

        // 30 px period, 15 px high: high, edges at both phases, low, off-plot
        apply_setting(ptcr_pkg::VS_1000, ptcr_pkg::TS_100, 16'd3300, 16'd0, 24'd100,
                      24'd50, 16'hFFFF, 16'h0000);
        send_column(9'd0);
        send_column(9'd14);
        send_column(9'd15);
        send_column(9'd29);
        send_column(9'd30);
        send_column(9'd299);
        send_column(9'd300);
        send_column(9'd256);
        drain_results();

        // unused volt code, levels and times at their maximum, rows clamp at the top
        apply_setting(VS_UNUSED, ptcr_pkg::TS_5000, 16'hFFFF, 16'hFFFF, 24'hFFFFFF,
                      24'hFFFFFF, 16'h0000, 16'hFFFF);
        send_column(9'd0);
        send_column(9'd298);
        drain_results();

        // high time beyond the period is clamped; high level on the zero line
        apply_setting(ptcr_pkg::VS_3300, ptcr_pkg::TS_500, 16'd0, 16'd40000, 24'd1000,
                      24'd2000, 16'h1234, 16'h5A5A);
        send_column(9'd0);
        send_column(9'd59);
        send_column(9'd60);
        drain_results();

        // period below one pixel: every column is an edge
        apply_setting(ptcr_pkg::VS_1000, ptcr_pkg::TS_5000, 16'd1000, 16'd500, 24'd1,
                      24'd0, 16'hA5A5, 16'h0F0F);
        send_column(9'd0);
        send_column(9'd7);
        drain_results();

        // high time below one pixel is widened to one
        apply_setting(VS_5000, ptcr_pkg::TS_5000, 16'd20000, 16'd100, 24'd5000, 24'd1,
                      16'h00FF, 16'hFF00);
        send_column(9'd0);
        send_column(9'd1);
        send_column(9'd2);
        drain_results();

        while (random_sent < RANDOM_COLUMNS) begin
            volt  = 2'($urandom_range(0, 3));
            tsc   = 2'($urandom_range(0, 3));
            usdiv = us_per_div_tab[tsc];
            case ($urandom_range(0, 15))
                0:       span_us = 0;
                1:       span_us = $urandom_range(1, usdiv / 30);
                2, 3:    span_us = $urandom_range(0, 24'hFFFFFF);
                default: span_us = $urandom_range(1, usdiv * 10);
            endcase
            high_cap = (span_us * 2 > 24'hFFFFFF) ? 24'hFFFFFF : span_us * 2;
            case ($urandom_range(0, 5))
                0:       high_us = 0;
                1:       high_us = span_us;
                2:       high_us = $urandom_range(span_us, high_cap);
                3:       high_us = $urandom_range(0, 24'hFFFFFF);
                default: high_us = $urandom_range(0, span_us);
            endcase
            apply_setting(volt, tsc, rand_millivolts(), rand_millivolts(),
                          24'(span_us), 24'(high_us),
                          16'($urandom_range(0, 16'hFFFF)),
                          16'($urandom_range(0, 16'hFFFF)));

            count = $urandom_range(20, 80);
            sender_burst = ($urandom_range(0, 3) == 0);
            // one phase fills the block against a stalled receiver
            if (phase_no == 2) begin
                hold_requests <= hold_requests + 1;
                sender_burst = 1'b1;
                count = 45;
            end
            repeat (count) begin
                if ($urandom_range(0, 99) < 85) send_column(COLW'($urandom_range(0, 299)));
                else send_column(COLW'($urandom_range(300, 511)));
                random_sent++;
            end
            drain_results();
            phase_no++;
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d columns under %0d register settings, %0d results checked",
                 columns_sent, settings_applied, results_checked);
        $display("Input held off by full for %0d cycles", full_stall_cycles);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
